/* rtl/base64_stream_encoder_top_defines.svh */
// assertion macros for the base64 stream encoder
// used by base64_stream_encoder_top; expects clk and rst_n in scope
`ifndef BASE64_STREAM_ENCODER_TOP_DEFINES_SVH
`define BASE64_STREAM_ENCODER_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define B64E_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define B64E_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/b64e_pkg.sv */
// shared types, constants and the alphabet lookup of the base64 encoder
// no dependencies
`timescale 1ns / 1ps

package b64e_pkg;

  localparam int CHAR_W  = 8;
  localparam int BYTE_W  = 8;
  localparam int SEXT_W  = 6;
  localparam int SLOTS   = 4;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int NCHR_W  = $clog2(SLOTS + 2);

  // transaction queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h3D;

  // pending bit counts
  localparam logic [2:0] LEFT_0 = 3'd0;
  localparam logic [2:0] LEFT_2 = 3'd2;
  localparam logic [2:0] LEFT_4 = 3'd4;

  // one encoded burst: up to four characters
  typedef struct packed {
    logic [SLOTS-1:0][CHAR_W-1:0] chars;
    logic [SLOT_W-1:0]            n_m1;
    logic                         fin;
  } job_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // encoder state seen by the top for checking
  typedef struct packed {
    logic [2:0] cnt;
    logic [1:0] grp;
  } enc_st_t;

  // standard alphabet
  function automatic logic [CHAR_W-1:0] b64_char(input logic [SEXT_W-1:0] s);
    logic [CHAR_W-1:0] c;
    case (s) inside
      [6'd0 : 6'd25]:  c = 8'h41 + CHAR_W'(s);
      [6'd26 : 6'd51]: c = 8'h61 + CHAR_W'(s - 6'd26);
      [6'd52 : 6'd61]: c = 8'h30 + CHAR_W'(s - 6'd52);
      6'd62:           c = 8'h2B;
      default:         c = 8'h2F;
    endcase
    return c;
  endfunction

endpackage

/* rtl/b64e_front.sv */
// front end: accepts bytes, keeps pending bits and builds character bursts
// depends on b64e_pkg
`timescale 1ns / 1ps

module b64e_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_final_byte,
  input  b64e_pkg::q_stat_t          q_stat,
  output logic                       push,
  output b64e_pkg::job_t             push_job,
  output b64e_pkg::enc_st_t          enc_st
);
  import b64e_pkg::*;

  logic [3:0]  bits_r, bits_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [1:0]  grp_r, grp_nxt;

  logic [2:0]             cnt_s;
  logic [11:0]            acc;
  logic [SEXT_W-1:0]      s0, s1, sf;
  logic [NCHR_W-1:0]      nbase, nchar, total;
  logic [3:0]             rem_bits;
  logic [2:0]             rem_cnt;
  logic [1:0]             grp_end, pad;
  logic [SLOTS-1:0][CHAR_W-1:0] base;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;
  assign enc_st   = '{cnt: cnt_r, grp: grp_r};

  // split the accumulated bits into sextets
  always_comb begin
    cnt_s    = (cnt_r == LEFT_2 || cnt_r == LEFT_4) ? cnt_r : LEFT_0;
    acc      = {bits_r, in_data_byte};
    s0       = '0;
    s1       = '0;
    rem_bits = '0;
    rem_cnt  = LEFT_0;
    nbase    = NCHR_W'(1);
    case (cnt_s)
      LEFT_2: begin
        s0       = acc[9:4];
        rem_bits = acc[3:0];
        rem_cnt  = LEFT_4;
      end
      LEFT_4: begin
        s0    = acc[11:6];
        s1    = acc[5:0];
        nbase = NCHR_W'(2);
      end
      default: begin
        s0       = acc[7:2];
        rem_bits = {2'b00, acc[1:0]};
        rem_cnt  = LEFT_2;
      end
    endcase
  end

  // burst assembly: data characters, flush character and padding
  always_comb begin
    base    = {SLOTS{PAD_CHAR}};
    base[0] = b64_char(s0);
    if (nbase == NCHR_W'(2)) begin
      base[1] = b64_char(s1);
    end
    sf    = (rem_cnt == LEFT_4) ? {rem_bits, 2'b00} : {rem_bits[1:0], 4'b0000};
    nchar = nbase;
    if (in_final_byte && rem_cnt != LEFT_0) begin
      base[nbase[SLOT_W-1:0]] = b64_char(sf);
      nchar = nbase + NCHR_W'(1);
    end
    grp_end = grp_r + nchar[1:0];
    pad     = in_final_byte ? 2'(-grp_end) : 2'd0;
    total   = nchar + NCHR_W'(pad);
    if (total > NCHR_W'(SLOTS)) begin
      total = NCHR_W'(SLOTS);
    end
    push_job.chars = base;
    push_job.n_m1  = SLOT_W'(total - NCHR_W'(1));
    push_job.fin   = in_final_byte;
  end

  // next pending state
  always_comb begin
    bits_nxt = bits_r;
    cnt_nxt  = cnt_r;
    grp_nxt  = grp_r;
    if (push) begin
      if (in_final_byte) begin
        bits_nxt = '0;
        cnt_nxt  = LEFT_0;
        grp_nxt  = '0;
      end else begin
        bits_nxt = rem_bits;
        cnt_nxt  = rem_cnt;
        grp_nxt  = grp_r + nbase[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      cnt_r  <= LEFT_0;
      grp_r  <= '0;
    end else begin
      bits_r <= bits_nxt;
      cnt_r  <= cnt_nxt;
      grp_r  <= grp_nxt;
    end
  end

endmodule

/* rtl/b64e_queue.sv */
// short queue of character bursts between front and back
// depends on b64e_pkg
`timescale 1ns / 1ps

module b64e_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  b64e_pkg::job_t     push_job,
  input  logic               pop,
  output b64e_pkg::job_t     head_job,
  output b64e_pkg::q_stat_t  q_stat
);
  import b64e_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head_job     = mem_r[rd_ptr_r];
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;

  // pointer and fill tracking
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // burst storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* rtl/b64e_back.sv */
// back end: serialises queued bursts into one character per transaction
// depends on b64e_pkg
`timescale 1ns / 1ps

module b64e_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  b64e_pkg::job_t              head_job,
  input  b64e_pkg::q_stat_t           q_stat,
  output logic                        pop,
  output logic [b64e_pkg::SLOT_W-1:0] slot_idx,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_char,
  output logic                        out_final_char
);
  import b64e_pkg::*;

  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              valid_r, valid_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              fin_r, fin_nxt;
  logic              load, take, last_slot;

  assign load      = !valid_r || out_ready;
  assign take      = load && !q_stat.empty;
  assign last_slot = (idx_r == head_job.n_m1);
  assign pop       = take && last_slot;
  assign slot_idx  = idx_r;

  // output register and slot walk
  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    char_nxt  = char_r;
    fin_nxt   = fin_r;
    if (load) begin
      valid_nxt = take;
    end
    if (take) begin
      char_nxt = head_job.chars[idx_r];
      fin_nxt  = head_job.fin && last_slot;
      idx_nxt  = last_slot ? '0 : idx_r + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    fin_r  <= fin_nxt;
  end

  assign out_valid      = valid_r;
  assign out_char       = char_r;
  assign out_final_char = fin_r;

endmodule

/* rtl/base64_stream_encoder_top.sv */
// channel   | ports                                   | direction
// input     | in_valid in_ready in_data_byte in_final_byte | byte in
// result    | out_valid out_ready out_char out_final_char   | character out
//
// each byte gives a burst of one to four characters; the output emits one
// character per cycle while a burst is queued and out_ready is high.
// a two-entry burst queue separates byte intake from character output.
// reset is synchronous, active low; it empties the queue and the pending bits.
// a byte's first character is registered in the burst queue and then in the
// output register before it shows on out_char with out_valid.
// depends on b64e_pkg, b64e_front, b64e_queue, b64e_back and the defines header
`timescale 1ns / 1ps
`include "base64_stream_encoder_top_defines.svh"

module base64_stream_encoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_final_char
);
  import b64e_pkg::*;

  job_t              push_job, head_job;
  q_stat_t           q_stat;
  enc_st_t           enc_st;
  logic              push, pop;
  logic [SLOT_W-1:0] slot_idx;
  logic              in_fin_acc, st_empty, st_paired;

  // byte intake and burst building
  b64e_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .q_stat        (q_stat),
    .push          (push),
    .push_job      (push_job),
    .enc_st        (enc_st)
  );

  // burst queue
  b64e_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  // character output
  b64e_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_job       (head_job),
    .q_stat         (q_stat),
    .pop            (pop),
    .slot_idx       (slot_idx),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_final_char (out_final_char)
  );

  // terms for the checks
  assign in_fin_acc = in_valid && in_ready && in_final_byte;
  assign st_empty   = (enc_st.cnt == LEFT_0) && (enc_st.grp == 2'd0);
  assign st_paired  = st_empty ||
                      ((enc_st.cnt == LEFT_2) && (enc_st.grp == 2'd1)) ||
                      ((enc_st.cnt == LEFT_4) && (enc_st.grp == 2'd2));

  // checks
  `B64E_ASSERT_NEXT(a_final_clears, in_fin_acc, st_empty, "state not empty after final byte")
  `B64E_ASSERT_NOW(a_state_pairing, 1'b1, st_paired, "pending bits and group count disagree")
  `B64E_ASSERT_NOW(a_idle_slot, q_stat.empty, slot_idx == '0, "slot index moved with empty queue")

endmodule
